@@ hw/rtl/dsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and constants for the driven spring chain
// Field widths, register reset values, register indexes and ALU control.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int POS_W    = 32;
  localparam int LAP_W    = 34;
  localparam int STIFF_W  = 24;
  localparam int DT_W     = 16;
  localparam int AP_W     = 7;
  localparam int DRV_W    = 22;
  localparam int IDX_W    = 6;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_STIFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd2;

  localparam logic [STIFF_W-1:0] STIFF_RST  = 24'd1310720;
  localparam logic [DT_W-1:0]    STEP_RST   = 16'd655;
  localparam logic [AP_W-1:0]    ACTIVE_RST = 7'd64;

  typedef struct packed {
    logic mul_en;
    logic rnd_en;
    logic add_en;
  } alu_ctl_t;

endpackage

@@ hw/rtl/dsc_alu.sv @@
// ----------------------------------------------------------------------------
// dsc_alu: shared multiply, round and accumulate unit
// Multiply, round the Q16 product to nearest with saturation, then add a
// base value with saturation. One register per step.
// ----------------------------------------------------------------------------
module dsc_alu (
  input  logic                                   clk,
  input  dsc_pkg::alu_ctl_t                      ctl,
  input  logic signed [dsc_pkg::LAP_W-1:0]       mul_a,
  input  logic        [dsc_pkg::STIFF_W-1:0]     mul_b,
  input  logic signed [dsc_pkg::POS_W-1:0]       add_base,
  output logic signed [dsc_pkg::POS_W-1:0]       res
);

  localparam int PROD_W = 60;
  localparam logic signed [PROD_W-1:0] SAT_HI = 60'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_LO = -60'sd2147483648;
  localparam logic signed [PROD_W-1:0] RND_HALF = 60'sd32768;

  logic signed [PROD_W-1:0]          prod_r;
  logic signed [PROD_W-1:0]          prod_w;
  logic signed [PROD_W-1:0]          rnd_sum;
  logic signed [PROD_W-1:0]          rnd_shift;
  logic signed [dsc_pkg::POS_W-1:0]  rnd_r;
  logic signed [dsc_pkg::POS_W:0]    add_sum;
  logic signed [dsc_pkg::POS_W-1:0]  acc_r;

  function automatic logic signed [dsc_pkg::POS_W-1:0] sat32(
    input logic signed [PROD_W-1:0] v
  );
    logic signed [dsc_pkg::POS_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[dsc_pkg::POS_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[dsc_pkg::POS_W-1:0];
    end else begin
      r = v[dsc_pkg::POS_W-1:0];
    end
    return r;
  endfunction

  assign prod_w    = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));
  assign rnd_sum   = prod_r + RND_HALF;
  assign rnd_shift = rnd_sum >>> 16;
  assign add_sum   = (dsc_pkg::POS_W+1)'(add_base) + (dsc_pkg::POS_W+1)'(rnd_r);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_w;
    end
    if (ctl.rnd_en) begin
      rnd_r <= sat32(rnd_shift);
    end
    if (ctl.add_en) begin
      acc_r <= sat32(PROD_W'(add_sum));
    end
  end

  assign res = acc_r;

endmodule

@@ hw/rtl/driven_spring_chain_step.sv @@
// ----------------------------------------------------------------------------
// driven_spring_chain_step: driven mass-spring chain, one tick per beat
// Order: the active positions are read out first, one beat per pass through the
//   read, load and wait states, held while the sink is not ready; the update follows the readout.
// Throughput: a new input beat is taken only once readout and update are done;
//   the update runs on the shared multiplier, used three times per point.
// Reset: synchronous; positions and velocities read as zero until written.
// ----------------------------------------------------------------------------
module driven_spring_chain_step #(
  parameter int MAX_POINTS = dsc_pkg::MAX_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // drive_position [21:0]
  input  logic [dsc_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // point_index [5:0], position_value [37:6]
  output logic [dsc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [dsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dsc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = dsc_pkg::POS_W;
  localparam int LW = dsc_pkg::LAP_W;
  localparam logic [dsc_pkg::AP_W-1:0] MAXP = dsc_pkg::AP_W'(MAX_POINTS);
  localparam logic [dsc_pkg::AP_W-1:0] MINP = dsc_pkg::AP_W'(2);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_OUT_RD = 4'd1;
  localparam logic [3:0] ST_OUT_LD = 4'd2;
  localparam logic [3:0] ST_OUT_WT = 4'd3;
  localparam logic [3:0] ST_P0     = 4'd4;
  localparam logic [3:0] ST_P1     = 4'd5;
  localparam logic [3:0] ST_LAP    = 4'd6;
  localparam logic [3:0] ST_MUL    = 4'd7;
  localparam logic [3:0] ST_RND    = 4'd8;
  localparam logic [3:0] ST_ADD    = 4'd9;
  localparam logic [3:0] ST_PWR    = 4'd10;

  localparam logic [1:0] OP_ACC = 2'd0;
  localparam logic [1:0] OP_VEL = 2'd1;
  localparam logic [1:0] OP_POS = 2'd2;

  logic [3:0]                        state_r, state_nxt;
  logic [1:0]                        op_r;
  logic [CW-1:0]                     i_r, n_r;
  logic [CW-1:0]                     adv_idx, idx_p2;
  logic                              is_last;
  logic [dsc_pkg::AP_W-1:0]          n_clamp;

  logic [dsc_pkg::STIFF_W-1:0]       stiff_r;
  logic [dsc_pkg::DT_W-1:0]          dt_r;
  logic [dsc_pkg::AP_W-1:0]          active_r;

  logic signed [PW-1:0]              drive_r, pm_r, pc_r, pn_r, v_r;
  logic signed [LW-1:0]              lap_r;

  logic                              out_valid_r, out_last_r;
  logic [dsc_pkg::IDX_W-1:0]         out_idx_r;
  logic [PW-1:0]                     out_pos_r;

  logic [PW-1:0]                     pos_mem [MAX_POINTS];
  logic [PW-1:0]                     vel_mem [MAX_POINTS];
  logic [MAX_POINTS-1:0]             pos_vld_r, vel_vld_r;
  logic [PW-1:0]                     pos_rd_r, vel_rd_r;
  logic                              pos_rv_r, vel_rv_r;
  logic signed [PW-1:0]              pos_rd, vel_rd;

  logic [IW-1:0]                     pos_raddr, vel_raddr, wr_addr;
  logic                              pos_we, vel_we;
  logic [PW-1:0]                     pos_wdata, vel_wdata;

  dsc_pkg::alu_ctl_t                 alu_ctl;
  logic signed [LW-1:0]              mul_a;
  logic [dsc_pkg::STIFF_W-1:0]       mul_b;
  logic signed [PW-1:0]              add_base;
  logic signed [PW-1:0]              alu_res;

  logic                              in_beat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  assign adv_idx = i_r + CW'(1);
  assign idx_p2  = i_r + CW'(2);
  assign is_last = (adv_idx == n_r);

  assign n_clamp = (active_r < MINP) ? MINP : ((active_r > MAXP) ? MAXP : active_r);

  assign pos_rd = pos_rv_r ? $signed(pos_rd_r) : '0;
  assign vel_rd = vel_rv_r ? $signed(vel_rd_r) : '0;

  // memory addressing and writes
  always_comb begin
    unique case (state_r)
      ST_OUT_RD: pos_raddr = i_r[IW-1:0];
      ST_P0:     pos_raddr = IW'(1);
      default:   pos_raddr = idx_p2[IW-1:0];
    endcase
    vel_raddr = adv_idx[IW-1:0];
    wr_addr   = (state_r == ST_P0) ? '0 : i_r[IW-1:0];
    pos_we    = (state_r == ST_P0) || (state_r == ST_PWR);
    pos_wdata = (state_r == ST_P0) ? drive_r : alu_res;
    vel_we    = (state_r == ST_P0) || ((state_r == ST_MUL) && (op_r == OP_POS));
    vel_wdata = (state_r == ST_P0) ? '0 : alu_res;
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[wr_addr] <= pos_wdata;
    end
    if (vel_we) begin
      vel_mem[wr_addr] <= vel_wdata;
    end
    pos_rd_r <= pos_mem[pos_raddr];
    vel_rd_r <= vel_mem[vel_raddr];
    pos_rv_r <= pos_vld_r[pos_raddr];
    vel_rv_r <= vel_vld_r[vel_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r <= '0;
      vel_vld_r <= '0;
    end else begin
      if (pos_we) begin
        pos_vld_r[wr_addr] <= 1'b1;
      end
      if (vel_we) begin
        vel_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // shared unit operands
  always_comb begin
    alu_ctl.mul_en = (state_r == ST_MUL);
    alu_ctl.rnd_en = (state_r == ST_RND);
    alu_ctl.add_en = (state_r == ST_ADD);
    case (op_r)
      OP_ACC: begin
        mul_a    = is_last ? '0 : lap_r;
        mul_b    = stiff_r;
        add_base = '0;
      end
      OP_VEL: begin
        mul_a    = LW'(alu_res);
        mul_b    = dsc_pkg::STIFF_W'(dt_r);
        add_base = v_r;
      end
      default: begin
        mul_a    = LW'(alu_res);
        mul_b    = dsc_pkg::STIFF_W'(dt_r);
        add_base = pc_r;
      end
    endcase
  end

  dsc_alu u_alu (
    .clk      (clk),
    .ctl      (alu_ctl),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .add_base (add_base),
    .res      (alu_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_beat) state_nxt = ST_OUT_RD;
      ST_OUT_RD: state_nxt = ST_OUT_LD;
      ST_OUT_LD: state_nxt = ST_OUT_WT;
      ST_OUT_WT: begin
        if (out_tready) begin
          state_nxt = out_last_r ? ST_P0 : ST_OUT_RD;
        end
      end
      ST_P0:     state_nxt = ST_P1;
      ST_P1:     state_nxt = ST_LAP;
      ST_LAP:    state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_RND;
      ST_RND:    state_nxt = ST_ADD;
      ST_ADD:    state_nxt = (op_r == OP_POS) ? ST_PWR : ST_MUL;
      ST_PWR:    state_nxt = is_last ? ST_IDLE : ST_LAP;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_ACC;
      i_r         <= '0;
      n_r         <= CW'(2);
      out_valid_r <= 1'b0;
      stiff_r     <= dsc_pkg::STIFF_RST;
      dt_r        <= dsc_pkg::STEP_RST;
      active_r    <= dsc_pkg::ACTIVE_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          dsc_pkg::CFG_STIFF:  stiff_r  <= cfg_wdata[dsc_pkg::STIFF_W-1:0];
          dsc_pkg::CFG_STEP:   dt_r     <= cfg_wdata[dsc_pkg::DT_W-1:0];
          dsc_pkg::CFG_ACTIVE: active_r <= cfg_wdata[dsc_pkg::AP_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            n_r <= CW'(n_clamp);
            i_r <= '0;
          end
        end
        ST_OUT_LD: out_valid_r <= 1'b1;
        ST_OUT_WT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            i_r         <= out_last_r ? '0 : adv_idx;
          end
        end
        ST_P1: begin
          i_r  <= adv_idx;
          op_r <= OP_ACC;
        end
        ST_ADD: begin
          if (op_r == OP_ACC) begin
            op_r <= OP_VEL;
          end else if (op_r == OP_VEL) begin
            op_r <= OP_POS;
          end
        end
        ST_PWR: begin
          i_r  <= adv_idx;
          op_r <= OP_ACC;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          drive_r <= PW'($signed(in_tdata[dsc_pkg::DRV_W-1:0]));
        end
      end
      ST_OUT_LD: begin
        out_idx_r  <= dsc_pkg::IDX_W'(i_r);
        out_pos_r  <= pos_rd;
        out_last_r <= is_last;
      end
      ST_P1: begin
        pm_r <= drive_r;
        pc_r <= pos_rd;
      end
      ST_LAP: begin
        pn_r  <= pos_rd;
        v_r   <= vel_rd;
        lap_r <= LW'(pm_r) - (LW'(pc_r) <<< 1) + LW'(pos_rd);
      end
      ST_PWR: begin
        pm_r <= pc_r;
        pc_r <= pn_r;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_pos_r, out_idx_r};

endmodule

@@ hw/rtl/dsc_chk.sv @@
// ----------------------------------------------------------------------------
// dsc_chk: port-level checks for the driven spring chain
// Watches the stream ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module dsc_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [dsc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              out_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result beat is pending");

  a_gap_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("result beat without the read gap");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result beat changed");

endmodule

bind driven_spring_chain_step dsc_chk u_dsc_chk (.*);

@@ bench/driven_spring_chain_step_tb.sv @@
// ----------------------------------------------------------------------------
// driven_spring_chain_step_tb: self-checking bench for the driven spring chain
// Sends drive ticks over the input stream and checks every reported position
// beat against a fixed-point predictor of the chain. The run covers extreme
// drives, point counts outside the legal range, zero and full step sizes,
// saturating stiffness, and four mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module driven_spring_chain_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE          = 1000;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int RANDOM_PHASES   = 14;
  localparam int TICKS_PER_PHASE = 19;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idling_t;

  class chain_scoreboard;
    typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [POS_W-1:0] value;
      logic             last;
    } beat_t;

    logic [STIFF_W-1:0] stiffness;
    logic [DT_W-1:0]    dt;
    logic [AP_W-1:0]    active;
    int                 positions[MAX_POINTS_DEF];
    int                 velocities[MAX_POINTS_DEF];
    beat_t              position_q[$];
    int                 mismatches;
    int                 beats_seen;
    int                 ticks_seen;
    int                 clamp_hits;

    function void reset_state();
      stiffness  = STIFF_RST;
      dt         = STEP_RST;
      active     = ACTIVE_RST;
      foreach (positions[i]) begin
        positions[i]  = 0;
        velocities[i] = 0;
      end
      mismatches = 0;
      beats_seen = 0;
      ticks_seen = 0;
      clamp_hits = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_STIFF:  stiffness = val[STIFF_W-1:0];
        CFG_STEP:   dt        = val[DT_W-1:0];
        CFG_ACTIVE: active    = val[AP_W-1:0];
        default: ;
      endcase
    endfunction

    function int points();
      if (active < 2) return 2;
      if (active > MAX_POINTS_DEF) return MAX_POINTS_DEF;
      return int'(active);
    endfunction

    function int clamp32(longint v);
      if (v > 64'sh7FFF_FFFF) begin
        clamp_hits++;
        return 32'sh7FFF_FFFF;
      end
      if (v < -64'sh8000_0000) begin
        clamp_hits++;
        return 32'sh8000_0000;
      end
      return int'(v);
    endfunction

    // round to nearest, ties upward, then saturate
    function int scale_q16(longint a, longint b);
      longint p;
      p = a * b + 64'sd32768;
      return clamp32(p >>> 16);
    endfunction

    function void note_drive(logic [DRV_W-1:0] raw);
      int     n;
      int     accel[MAX_POINTS_DEF];
      longint lap;
      beat_t  b;
      n = points();
      ticks_seen++;
      for (int i = 0; i < n; i++) begin
        b.index = i[IDX_W-1:0];
        b.value = positions[i];
        b.last  = (i == n - 1);
        position_q.push_back(b);
      end
      positions[0]  = int'($signed(raw));
      velocities[0] = 0;
      accel[0]      = 0;
      for (int i = 1; i + 1 < n; i++) begin
        lap = longint'(positions[i-1]) - 2 * longint'(positions[i])
            + longint'(positions[i+1]);
        accel[i] = scale_q16(lap, longint'(stiffness));
      end
      accel[n-1] = 0;
      for (int i = 1; i < n; i++) begin
        velocities[i] = clamp32(longint'(velocities[i])
                                + longint'(scale_q16(accel[i], longint'(dt))));
        positions[i]  = clamp32(longint'(positions[i])
                                + longint'(scale_q16(velocities[i], longint'(dt))));
      end
    endfunction

    function void check_beat(logic [OUT_TDATA_W-1:0] data, logic last);
      beat_t want;
      beats_seen++;
      if (position_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got index %0d value %0d last %0b",
                 $time, data[IDX_W-1:0], $signed(data[IDX_W +: POS_W]), last);
        mismatches++;
        return;
      end
      want = position_q.pop_front();
      if (data[IDX_W-1:0] != want.index) begin
        $display("%0t: point_index expected %0d got %0d", $time, want.index,
                 data[IDX_W-1:0]);
        mismatches++;
      end
      if (data[IDX_W +: POS_W] != want.value) begin
        $display("%0t: position_value (point %0d) expected %0d got %0d", $time,
                 want.index, $signed(want.value), $signed(data[IDX_W +: POS_W]));
        mismatches++;
      end
      if (last != want.last) begin
        $display("%0t: last_point (point %0d) expected %0b got %0b", $time,
                 want.index, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  chain_scoreboard sb;
  int send_idle  = 0;
  int recv_stall = 0;
  int quiet      = 0;
  int settings   = 0;
  int walk_pos   = 0;

  driven_spring_chain_step DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_beat(out_tdata, out_tlast);
    end
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic set_idling(idling_t mode);
    case (mode)
      IDLE_NONE: begin send_idle = 0;  recv_stall = 0;  end
      IDLE_SEND: begin send_idle = 46; recv_stall = 0;  end
      IDLE_RECV: begin send_idle = 0;  recv_stall = 46; end
      IDLE_BOTH: begin send_idle = 29; recv_stall = 29; end
      default: ;
    endcase
  endtask

  task automatic send_drive(logic [DRV_W-1:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-DRV_W){1'b0}}, d};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_drive(d);
  endtask

  // hold off until every expected beat is in, then wait out the given settle time
  task automatic wait_drained(int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.position_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.apply_reg(idx, val);
  endtask

  task automatic apply_config(logic [STIFF_W-1:0] stiff, logic [DT_W-1:0] dt,
                              logic [AP_W-1:0] act, bit junk);
    cfg_write(CFG_STIFF, stiff);
    cfg_write(CFG_STEP, {8'($urandom), dt});
    cfg_write(CFG_ACTIVE, {17'($urandom), act});
    if (junk) cfg_write(CFG_UNUSED, 24'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  function automatic logic [DRV_W-1:0] next_drive();
    int r;
    r = $urandom_range(9);
    if (r == 0) return $urandom_range(1) ? 22'h1FFFFF : 22'h200000;
    if (r == 1) return 22'($urandom);
    walk_pos = walk_pos + $urandom_range(262144) - 131072;
    if (walk_pos > 1048576) walk_pos = 1048576;
    if (walk_pos < -1048576) walk_pos = -1048576;
    return walk_pos[DRV_W-1:0];
  endfunction

  function automatic logic [STIFF_W-1:0] pick_stiffness();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom);
      default: return 24'($urandom_range(2621440, 65536));
    endcase
  endfunction

  function automatic logic [DT_W-1:0] pick_step();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1000, 100));
    endcase
  endfunction

  function automatic logic [AP_W-1:0] pick_points();
    case ($urandom_range(9))
      0:       return 7'($urandom_range(1));
      1:       return 7'($urandom_range(127, 65));
      2:       return 7'd64;
      default: return 7'($urandom_range(16, 2));
    endcase
  endfunction

  initial begin
    sb = new;
    sb.reset_state();
    set_idling(IDLE_NONE);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, full chain, drive extremes
    send_drive(22'h000000);
    send_drive(22'h1FFFFF);
    send_drive(22'h200000);
    send_drive(22'h100000);
    send_drive(22'h300000);
    send_drive(22'h000001);
    send_drive(22'h3FFFFF);
    wait_drained(SETTLE);

    // count below two, maximum stiffness and step, write past the register map
    apply_config(24'hFFFFFF, 16'hFFFF, 7'd0, 1'b1);
    send_drive(22'h1FFFFF);
    send_drive(22'h200000);
    send_drive(22'h1FFFFF);
    send_drive(22'h200000);
    wait_drained(SETTLE);

    // count of one, zero step, zero stiffness
    apply_config(24'h000000, 16'h0000, 7'd1, 1'b0);
    send_drive(22'h155555);
    send_drive(22'h2AAAAA);
    send_drive(22'h000000);
    wait_drained(SETTLE);

    // count above the maximum, saturating chain
    apply_config(24'hFFFFFF, 16'hFFFF, 7'd127, 1'b0);
    send_drive(22'h1FFFFF);
    send_drive(22'h200000);
    send_drive(22'h1FFFFF);
    wait_drained(SETTLE);

    // short chain whose far end is still moving
    apply_config(STIFF_RST, STEP_RST, 7'd3, 1'b0);
    send_drive(22'h000000);
    send_drive(22'h000000);
    send_drive(22'h100000);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained(SETTLE);
      apply_config(pick_stiffness(), pick_step(), pick_points(), $urandom_range(3) == 0);
      set_idling(idling_t'(p % 4));
      for (int k = 0; k < TICKS_PER_PHASE; k++) begin
        if ((p == 1 && k == TICKS_PER_PHASE / 2) || $urandom_range(15) == 0) begin
          wait_drained(0);
        end
        send_drive(next_drive());
      end
    end
    wait_drained(SETTLE);

    $display("Run: %0d ticks, %0d position beats, %0d register settings, %0d saturations.",
             sb.ticks_seen, sb.beats_seen, settings, sb.clamp_hits);
    $display("Point counts clamped both ways, zero and full step, four idling mixes.");
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
